### rtl/core/smm_pkg.sv
package smm_pkg;

  localparam int MAX_SIZE = 8;
  localparam int IDX_W    = 3;                         // fixed by the row and column fields
  localparam int CNT_W    = $clog2(MAX_SIZE + 1);      // holds a size from 0 up to MAX_SIZE
  localparam int ELEM_W   = 16;
  localparam int SIZE_W   = 4;
  localparam int PROD_W   = 34;
  localparam int SUM_W    = 2 * ELEM_W + $clog2(MAX_SIZE) + 1;

  localparam logic [PROD_W-1:0] PROD_MAX = {PROD_W{1'b1}};

  typedef enum logic [1:0] {
    OP_LOAD_FIRST  = 2'd0,
    OP_LOAD_SECOND = 2'd1,
    OP_START       = 2'd2,
    OP_UNUSED      = 2'd3
  } opcode_t;

  typedef enum logic {
    REG_SIZE_FIRST  = 1'b0,
    REG_SIZE_SECOND = 1'b1
  } reg_index_t;

  // One product element travelling down the chain of cells.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             mism;
    logic             last;
    logic [SUM_W-1:0] sum;
  } token_t;

  // Element write broadcast to every cell.
  typedef struct packed {
    logic              we_first;
    logic              we_second;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [ELEM_W-1:0] value;
  } load_t;

endpackage

### rtl/core/square_matrix_multiply.sv
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: opcode, row_index, col_index, element_value
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: out_row, out_col, product_value;
//                                             tuser: status; tlast: last
// cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
// A start with equal sizes n issues n*n products, one per cycle while the output
// is not stalled, through a chain of MAX_SIZE multiply-add cells; a size mismatch
// issues a single mismatch result. The issue rate of one product per cycle is set
// by the single multiplier in each cell. Reset is synchronous and clears the
// control state and the sizes to 8; matrix storage is not cleared. A stalled
// output freezes the whole chain, and no new request is taken until the last
// token of a start has reached the output register.
module square_matrix_multiply (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] opcode, [4:2] row_index, [7:5] col_index, [23:8] element_value
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] out_row, [5:3] out_col, [39:6] product_value
  output logic [39:0] m_axis_tdata,
  // [0] status
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  logic [smm_pkg::SIZE_W-1:0] size_first;
  logic [smm_pkg::SIZE_W-1:0] size_second;
  logic [smm_pkg::CNT_W-1:0]  size_n;
  logic                       busy;
  logic                       en;
  logic                       in_acc;
  logic                       start;
  smm_pkg::opcode_t           opcode;
  logic [smm_pkg::IDX_W-1:0]  in_row;
  logic [smm_pkg::IDX_W-1:0]  in_col;
  smm_pkg::load_t             load;
  smm_pkg::token_t            tok [smm_pkg::MAX_SIZE+1];
  smm_pkg::token_t            tail;
  logic [smm_pkg::PROD_W-1:0] tail_value;

  logic                       out_valid;
  logic [smm_pkg::IDX_W-1:0]  out_row;
  logic [smm_pkg::IDX_W-1:0]  out_col;
  logic [smm_pkg::PROD_W-1:0] out_value;
  logic                       out_status;
  logic                       out_last;

  // Configuration is always accepted; indexes beyond the two sizes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_first  <= smm_pkg::SIZE_W'(smm_pkg::MAX_SIZE);
      size_second <= smm_pkg::SIZE_W'(smm_pkg::MAX_SIZE);
    end else if (cfg_valid) begin
      if (cfg_index == {1'b0, smm_pkg::REG_SIZE_FIRST}) begin
        size_first <= cfg_data;
      end else if (cfg_index == {1'b0, smm_pkg::REG_SIZE_SECOND}) begin
        size_second <= cfg_data;
      end
    end
  end

  // Input side: one request at a time; a start holds the port until its run is done.
  assign s_axis_tready = !busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign opcode        = smm_pkg::opcode_t'(s_axis_tdata[1:0]);
  assign in_row        = s_axis_tdata[4:2];
  assign in_col        = s_axis_tdata[7:5];
  assign start         = in_acc && opcode == smm_pkg::OP_START;

  always_comb begin
    logic in_range;
    in_range       = (smm_pkg::CNT_W'(in_row) < smm_pkg::CNT_W'(smm_pkg::MAX_SIZE)) &&
                     (smm_pkg::CNT_W'(in_col) < smm_pkg::CNT_W'(smm_pkg::MAX_SIZE));
    load.we_first  = in_acc && in_range && opcode == smm_pkg::OP_LOAD_FIRST;
    load.we_second = in_acc && in_range && opcode == smm_pkg::OP_LOAD_SECOND;
    load.row       = in_row;
    load.col       = in_col;
    load.value     = s_axis_tdata[23:8];
  end

  // The chain moves whenever the output register is free or being emptied.
  assign en = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (en && tail.valid && tail.last) begin
      busy <= 1'b0;
    end
  end

  smm_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .start       (start),
    .size_first  (size_first),
    .size_second (size_second),
    .size_n      (size_n),
    .tok         (tok[0])
  );

  for (genvar k = 0; k < smm_pkg::MAX_SIZE; k++) begin : g_cell
    smm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .idx     (smm_pkg::IDX_W'(k)),
      .size_n  (size_n),
      .load    (load),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1])
    );
  end

  assign tail = tok[smm_pkg::MAX_SIZE];

  // Sums past the 34-bit range saturate; a mismatch result carries zero.
  always_comb begin
    if (tail.sum > smm_pkg::SUM_W'(smm_pkg::PROD_MAX)) begin
      tail_value = smm_pkg::PROD_MAX;
    end else begin
      tail_value = tail.sum[smm_pkg::PROD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= tail.valid;
    end
    if (en) begin
      out_row    <= tail.mism ? '0 : tail.row;
      out_col    <= tail.mism ? '0 : tail.col;
      out_value  <= tail_value;
      out_status <= tail.mism;
      out_last   <= tail.last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_value, out_col, out_row};
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;

`ifndef SYNTHESIS
  a_idle_seq_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !tok[0].valid)
    else $error("sequencer issues while the input port is open");

  a_start_issues: assert property (@(posedge clk) disable iff (rst)
    start |=> tok[0].valid && tok[0].row == '0 && tok[0].col == '0)
    else $error("start did not begin at the first product element");

  a_mism_last: assert property (@(posedge clk) disable iff (rst)
    tail.valid && tail.mism |-> tail.last)
    else $error("mismatch token not marked last");

  a_mism_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status |-> out_value == '0 && out_last)
    else $error("mismatch result carries a product");
`endif

endmodule

### rtl/core/smm_cell.sv
// Cell k holds column k of the first matrix and row k of the second, and adds
// first[r][k] * second[k][c] to the partial sum handed over by its neighbor.
module smm_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [smm_pkg::IDX_W-1:0] idx,
  input  logic [smm_pkg::CNT_W-1:0] size_n,
  input  smm_pkg::load_t            load,
  input  smm_pkg::token_t           tok_in,
  output smm_pkg::token_t           tok_out
);

  logic [smm_pkg::ELEM_W-1:0] first_col  [smm_pkg::MAX_SIZE];
  logic [smm_pkg::ELEM_W-1:0] second_row [smm_pkg::MAX_SIZE];

  logic [2*smm_pkg::ELEM_W-1:0] prod;
  logic                         active;
  smm_pkg::token_t              tok_next;

  always_ff @(posedge clk) begin
    if (load.we_first && load.col == idx) begin
      first_col[load.row] <= load.value;
    end
    if (load.we_second && load.row == idx) begin
      second_row[load.col] <= load.value;
    end
  end

  always_comb begin
    active   = tok_in.valid && !tok_in.mism &&
               (smm_pkg::CNT_W'(idx) < size_n);
    prod     = first_col[tok_in.row] * second_row[tok_in.col];
    tok_next = tok_in;
    if (active) begin
      tok_next.sum = tok_in.sum + smm_pkg::SUM_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (en) begin
      tok_out <= tok_next;
    end
  end

endmodule

### rtl/core/smm_seq.sv
// Walks the product elements in row-major order, one token per advance.
module smm_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       start,
  input  logic [smm_pkg::SIZE_W-1:0] size_first,
  input  logic [smm_pkg::SIZE_W-1:0] size_second,
  output logic [smm_pkg::CNT_W-1:0]  size_n,
  output smm_pkg::token_t            tok
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t                    state, state_next;
  logic [smm_pkg::IDX_W-1:0] row, row_next;
  logic [smm_pkg::IDX_W-1:0] col, col_next;
  logic                      mism, mism_next;
  logic [smm_pkg::CNT_W-1:0] size_n_next;
  logic [smm_pkg::IDX_W-1:0] top;
  logic                      at_end;

  always_comb begin
    top    = smm_pkg::IDX_W'(size_n - smm_pkg::CNT_W'(1));
    at_end = mism || (row == top && col == top);

    tok.valid = (state == S_RUN);
    tok.row   = row;
    tok.col   = col;
    tok.mism  = mism;
    tok.last  = at_end;
    tok.sum   = '0;

    state_next  = state;
    row_next    = row;
    col_next    = col;
    mism_next   = mism;
    size_n_next = size_n;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_RUN;
          row_next   = '0;
          col_next   = '0;
          mism_next  = (size_first != size_second);
          if (size_first == '0) begin
            size_n_next = smm_pkg::CNT_W'(1);
          end else if (smm_pkg::CNT_W'(size_first) > smm_pkg::CNT_W'(smm_pkg::MAX_SIZE)) begin
            size_n_next = smm_pkg::CNT_W'(smm_pkg::MAX_SIZE);
          end else begin
            size_n_next = smm_pkg::CNT_W'(size_first);
          end
        end
      end
      S_RUN: begin
        if (en) begin
          if (at_end) begin
            state_next = S_IDLE;
          end else if (col == top) begin
            col_next = '0;
            row_next = row + smm_pkg::IDX_W'(1);
          end else begin
            col_next = col + smm_pkg::IDX_W'(1);
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    row    <= row_next;
    col    <= col_next;
    mism   <= mism_next;
    size_n <= size_n_next;
  end

endmodule

### dv/smm_checker.sv
// Watches the three channels of the matrix multiplier, keeps its own copy of
// both matrices and both size registers, and checks every product element
// against the value worked out when the start request was accepted.
module smm_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  output int          mismatches,
  output int          results_due,
  output int          products_seen
);

  localparam logic [smm_pkg::SIZE_W-1:0] RESET_DIM = smm_pkg::SIZE_W'(smm_pkg::MAX_SIZE);

  typedef struct packed {
    logic [smm_pkg::IDX_W-1:0]  row;
    logic [smm_pkg::IDX_W-1:0]  col;
    logic [smm_pkg::PROD_W-1:0] value;
    logic                       status;
    logic                       last;
  } product_t;

  logic [smm_pkg::ELEM_W-1:0] first_elems  [smm_pkg::MAX_SIZE][smm_pkg::MAX_SIZE];
  logic [smm_pkg::ELEM_W-1:0] second_elems [smm_pkg::MAX_SIZE][smm_pkg::MAX_SIZE];
  logic [smm_pkg::SIZE_W-1:0] dim_first;
  logic [smm_pkg::SIZE_W-1:0] dim_second;
  product_t                   expected_products [$];

  function automatic bit field_ok(string name, longint unsigned want, longint unsigned got);
    if (want == got) return 1'b1;
    $error("%s: expected %0d, actual %0d", name, want, got);
    return 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    product_t                  item;
    logic [smm_pkg::IDX_W-1:0] row;
    logic [smm_pkg::IDX_W-1:0] col;
    logic [39:0]               acc;
    int                        n;
    bit                        ok;

    if (rst) begin
      dim_first  = RESET_DIM;
      dim_second = RESET_DIM;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == 2'(smm_pkg::REG_SIZE_FIRST)) dim_first = cfg_data;
        else if (cfg_index == 2'(smm_pkg::REG_SIZE_SECOND)) dim_second = cfg_data;
      end

      if (s_axis_tvalid && s_axis_tready) begin
        row = s_axis_tdata[4:2];
        col = s_axis_tdata[7:5];
        case (smm_pkg::opcode_t'(s_axis_tdata[1:0]))
          smm_pkg::OP_LOAD_FIRST: begin
            if (row < smm_pkg::MAX_SIZE && col < smm_pkg::MAX_SIZE)
              first_elems[row][col] = s_axis_tdata[23:8];
          end
          smm_pkg::OP_LOAD_SECOND: begin
            if (row < smm_pkg::MAX_SIZE && col < smm_pkg::MAX_SIZE)
              second_elems[row][col] = s_axis_tdata[23:8];
          end
          smm_pkg::OP_START: begin
            if (dim_first != dim_second) begin
              item        = '0;
              item.status = 1'b1;
              item.last   = 1'b1;
              expected_products.push_back(item);
            end else begin
              n = (dim_first == 0) ? 1 :
                  (dim_first > smm_pkg::MAX_SIZE) ? smm_pkg::MAX_SIZE : int'(dim_first);
              for (int r = 0; r < n; r++) begin
                for (int c = 0; c < n; c++) begin
                  acc = '0;
                  for (int k = 0; k < n; k++)
                    acc = acc + 40'(first_elems[r][k]) * 40'(second_elems[k][c]);
                  if (acc > 40'(smm_pkg::PROD_MAX)) acc = 40'(smm_pkg::PROD_MAX);
                  item.row    = smm_pkg::IDX_W'(r);
                  item.col    = smm_pkg::IDX_W'(c);
                  item.value  = acc[smm_pkg::PROD_W-1:0];
                  item.status = 1'b0;
                  item.last   = (r == n - 1) && (c == n - 1);
                  expected_products.push_back(item);
                end
              end
            end
          end
          default: ;
        endcase
      end

      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_products.size() == 0) begin
          $error("product with no request behind it: tdata %h, tuser %b, tlast %b",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
          mismatches++;
        end else begin
          item = expected_products.pop_front();
          ok = field_ok("out_row", item.row, m_axis_tdata[2:0])
             & field_ok("out_col", item.col, m_axis_tdata[5:3])
             & field_ok("product_value", item.value, m_axis_tdata[39:6])
             & field_ok("status", item.status, m_axis_tuser)
             & field_ok("last", item.last, m_axis_tlast);
          if (!ok) mismatches++;
          products_seen++;
        end
      end
    end
    results_due <= expected_products.size();
  end

endmodule

### dv/tb.sv
// Top of the matrix multiplier testbench. It only makes stimulus: element
// loads, start requests and size register writes, with random idling on the
// request side and random stalls on the result side. All prediction and
// checking lives in smm_checker, which hands back its failure count.
module tb;

  // Spare register indexes; writes to them must leave both sizes alone.
  localparam logic [1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [1:0] CFG_SPARE_HI = 2'd3;

  localparam int RANDOM_REQUESTS = 400;
  localparam int DRAIN_CYCLES    = 2 * smm_pkg::MAX_SIZE + 8;
  localparam int CYCLE_LIMIT     = 5000000;

  // How element values are chosen for one sequence of loads.
  typedef enum {VAL_ANY, VAL_UNIT, VAL_EDGE, VAL_MAX} value_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [3:0]  cfg_data = '0;

  int          mismatches;
  int          results_due;
  int          products_seen;

  // What the testbench believes is programmed and which elements hold data.
  // A start is only sent once every element it reads has been written.
  logic [3:0]  cur_first = 4'd8;
  logic [3:0]  cur_second = 4'd8;
  bit          wr_first  [smm_pkg::MAX_SIZE][smm_pkg::MAX_SIZE];
  bit          wr_second [smm_pkg::MAX_SIZE][smm_pkg::MAX_SIZE];
  bit          steady;
  int          requests_sent;
  int          starts_sent;
  int          reg_writes;
  int unsigned cycles;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  square_matrix_multiply DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  smm_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .results_due  (results_due),
    .products_seen(products_seen)
  );

  // The run is bounded by a cycle counter. The limit sits far above the
  // slowest correct run: every start at full size, every product waiting out
  // the longest stall and every request behind the longest gap.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: done, errors");
      $finish;
    end
  end

  // Result side back-pressure. Ready is mostly high with short stalls, now
  // and then a long one, and sometimes a long stretch with no stall at all.
  // Ready only changes after a wait on the clock, so it never falls and rises
  // in the same time step.
  initial begin
    forever begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(50, 200)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 6)) @(posedge clk);
        m_axis_tready <= 1'b0;
        case ($urandom_range(0, 19))
          0:       repeat ($urandom_range(20, 40)) @(posedge clk);
          1, 2, 3,
          4, 5:    repeat ($urandom_range(3, 8)) @(posedge clk);
          default: repeat ($urandom_range(1, 2)) @(posedge clk);
        endcase
      end
    end
  end

  // Gap after a request: mostly none, sometimes a few cycles, rarely long.
  // Inside a steady stretch requests go back to back.
  function automatic int idle_gap();
    int pick;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [15:0] elem_value(value_mode_t mode);
    case (mode)
      VAL_UNIT: return 16'($urandom_range(0, 32768));
      VAL_MAX:  return 16'hFFFF;
      VAL_EDGE: begin
        case ($urandom_range(0, 4))
          0:       return 16'h0000;
          1:       return 16'h0001;
          2:       return 16'h7FFF;
          3:       return 16'h8000;
          default: return 16'hFFFF;
        endcase
      end
      default:  return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Sends one request and waits for it to be taken. Valid is left high when
  // no gap follows, so the next request goes out on the very next cycle; a gap
  // or a wait for the block to go idle lowers it first.
  task automatic send(input smm_pkg::opcode_t op, input logic [2:0] r,
                      input logic [2:0] c, input logic [15:0] v);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v, c, r, op};
    do @(posedge clk); while (!s_axis_tready);
    case (op)
      smm_pkg::OP_LOAD_FIRST:  wr_first[r][c] = 1'b1;
      smm_pkg::OP_LOAD_SECOND: wr_second[r][c] = 1'b1;
      smm_pkg::OP_START:       starts_sent++;
      default: ;
    endcase
    if (op != smm_pkg::OP_UNUSED) requests_sent++;
    gap = idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the request side until every predicted product has come out, then
  // lets the pipeline settle. Loads give no result, so the extra cycles cover
  // one still in flight. The do-while skips the stale count of the edge at
  // which the last request was taken.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == 2'(smm_pkg::REG_SIZE_FIRST)) cur_first = data;
    else if (idx == 2'(smm_pkg::REG_SIZE_SECOND)) cur_second = data;
    reg_writes++;
    @(posedge clk);
  endtask

  // Size changes only happen with the block idle. Now and then both sizes
  // are rewritten with their current values, or a spare index is hit.
  task automatic set_sizes(input logic [3:0] a, input logic [3:0] b);
    if (a != cur_first || b != cur_second || $urandom_range(0, 9) == 0) begin
      wait_idle();
      write_reg(2'(smm_pkg::REG_SIZE_FIRST), a);
      write_reg(2'(smm_pkg::REG_SIZE_SECOND), b);
      if ($urandom_range(0, 4) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                  4'($urandom_range(0, 15)));
    end
  endtask

  // Loads every element that the next start will read and that has never
  // been written, or all of them when asked to rewrite. The sizes are equal
  // here; a raw size of zero acts as one and anything past the maximum as
  // the maximum.
  task automatic fill(input value_mode_t mode, input bit rewrite);
    int n;
    n = (cur_first == 0) ? 1 :
        (cur_first > smm_pkg::MAX_SIZE) ? smm_pkg::MAX_SIZE : int'(cur_first);
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        if (rewrite || !wr_first[r][c])
          send(smm_pkg::OP_LOAD_FIRST, 3'(r), 3'(c), elem_value(mode));
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        if (rewrite || !wr_second[r][c])
          send(smm_pkg::OP_LOAD_SECOND, 3'(r), 3'(c), elem_value(mode));
  endtask

  initial begin : stimulus
    int          base;
    int          seq;
    int          pick;
    logic [3:0]  a;
    logic [3:0]  b;
    value_mode_t mode;
    bit          rewrite;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. One by one matrices first: the largest element squared,
    // 8000 hex squared, a zero element, and two starts back to back.
    write_reg(2'(smm_pkg::REG_SIZE_FIRST), 4'd1);
    write_reg(2'(smm_pkg::REG_SIZE_SECOND), 4'd1);
    write_reg(CFG_SPARE_LO, 4'hF);
    write_reg(CFG_SPARE_HI, 4'h0);
    send(smm_pkg::OP_LOAD_FIRST, 3'd0, 3'd0, 16'hFFFF);
    send(smm_pkg::OP_LOAD_SECOND, 3'd0, 3'd0, 16'hFFFF);
    send(smm_pkg::OP_START, 3'd0, 3'd0, 16'h0000);
    send(smm_pkg::OP_LOAD_FIRST, 3'd0, 3'd0, 16'h8000);
    send(smm_pkg::OP_LOAD_SECOND, 3'd0, 3'd0, 16'h8000);
    send(smm_pkg::OP_START, 3'd7, 3'd7, 16'hFFFF);
    send(smm_pkg::OP_LOAD_FIRST, 3'd0, 3'd0, 16'h0000);
    send(smm_pkg::OP_START, 3'd0, 3'd0, 16'h0000);
    send(smm_pkg::OP_START, 3'd5, 3'd2, 16'h1234);

    // The unused opcode with all-ones and all-zeros content is dropped.
    send(smm_pkg::OP_UNUSED, 3'd7, 3'd7, 16'hFFFF);
    send(smm_pkg::OP_UNUSED, 3'd0, 3'd0, 16'h0000);

    // Loads at the far corner, read later by the full-size starts.
    send(smm_pkg::OP_LOAD_FIRST, 3'd7, 3'd7, 16'hFFFF);
    send(smm_pkg::OP_LOAD_SECOND, 3'd7, 3'd7, 16'h0001);

    // Differing sizes answer with a single mismatch result, also at the
    // extremes of the register range.
    set_sizes(4'd1, 4'd2);
    send(smm_pkg::OP_START, 3'd0, 3'd0, 16'h0000);
    set_sizes(4'd15, 4'd0);
    send(smm_pkg::OP_START, 3'd0, 3'd0, 16'h0000);

    // Equal sizes of zero act as one.
    set_sizes(4'd0, 4'd0);
    send(smm_pkg::OP_LOAD_FIRST, 3'd0, 3'd0, 16'h7FFF);
    send(smm_pkg::OP_START, 3'd0, 3'd0, 16'h0000);

    // A two by two product from edge values.
    set_sizes(4'd2, 4'd2);
    fill(VAL_EDGE, 1'b0);
    send(smm_pkg::OP_START, 3'd0, 3'd0, 16'h0000);

    // Hold the sender until every product so far has come back.
    wait_idle();

    // Random part. Each sequence picks sizes, loads a few random elements,
    // completes the matrices where needed and starts, with some noise and
    // extra starts mixed in. The first two sequences force a saturating
    // product and a size register at its top value.
    base = requests_sent;
    seq  = 0;
    while (requests_sent - base < RANDOM_REQUESTS) begin
      rewrite = 1'b0;
      mode    = value_mode_t'($urandom_range(0, 2));
      pick    = $urandom_range(0, 99);
      if (seq == 0) begin
        a       = 4'd5;
        b       = 4'd5;
        mode    = VAL_MAX;
        rewrite = 1'b1;
      end else if (seq == 1) begin
        a = 4'd15;
        b = 4'd15;
      end else if (pick < 60) begin
        a = 4'($urandom_range(1, 4));
        b = a;
      end else if (pick < 68) begin
        a = 4'($urandom_range(5, 15));
        b = a;
        if ($urandom_range(0, 3) == 0) begin
          mode    = VAL_MAX;
          rewrite = 1'b1;
        end
      end else if (pick < 76) begin
        a = 4'd0;
        b = 4'd0;
      end else if (pick < 88) begin
        a = 4'($urandom_range(0, 15));
        b = a + 4'($urandom_range(1, 15));
      end else begin
        a = cur_first;
        b = cur_second;
      end
      set_sizes(a, b);

      steady = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 9) == 0)
          send(smm_pkg::OP_UNUSED, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
               16'($urandom_range(0, 65535)));
        else
          send(smm_pkg::opcode_t'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
               3'($urandom_range(0, 7)), elem_value(mode));
      end
      if (cur_first == cur_second) fill(mode, rewrite);
      send(smm_pkg::OP_START, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
           16'($urandom_range(0, 65535)));
      if ($urandom_range(0, 4) == 0)
        send(smm_pkg::OP_START, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
             16'($urandom_range(0, 65535)));
      steady = 1'b0;
      if ($urandom_range(0, 19) == 0) wait_idle();
      seq++;
    end

    wait_idle();

    if (results_due != 0) $error("%0d products never came out", results_due);
    $display("tb: %0d requests in %0d sequences, %0d starts, %0d register writes",
             requests_sent, seq, starts_sent, reg_writes);
    $display("tb: %0d product results checked, %0d mismatching", products_seen, mismatches);
    if (mismatches == 0 && results_due == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

### square_matrix_multiply.f
rtl/core/smm_pkg.sv
rtl/core/smm_cell.sv
rtl/core/smm_seq.sv
rtl/core/square_matrix_multiply.sv
dv/smm_checker.sv
dv/tb.sv
